[rtl/kpd_pkg.sv]
// Shared types and constants of the keyboard packet decoder.
package kpd_pkg;

	// Protocol bytes
	localparam logic [7:0] SYNC_BYTE     = 8'hFF;
	localparam logic [7:0] CMD_SWITCH    = 8'h11;
	localparam logic [7:0] CMD_PTZ       = 8'h21;
	localparam logic [7:0] CMD_REGISTER  = 8'h41;
	localparam logic [7:0] ZOOM_IN_CODE  = 8'h40;
	localparam logic [7:0] ZOOM_OUT_CODE = 8'h80;

	// Packet byte positions
	localparam logic [2:0] POS_HUNT  = 3'd0;
	localparam logic [2:0] POS_CMD   = 3'd2;
	localparam logic [2:0] POS_B3    = 3'd3;
	localparam logic [2:0] POS_CAM   = 3'd4;
	localparam logic [2:0] POS_B5    = 3'd5;
	localparam logic [2:0] POS_B6    = 3'd6;
	localparam logic [2:0] POS_LAST  = 3'd7;

	// Flag bit positions in ptz_flags
	localparam int FLAG_STOP    = 0;
	localparam int FLAG_ZOOMIN  = 1;
	localparam int FLAG_ZOOMOUT = 2;
	localparam int FLAG_LEFT    = 3;
	localparam int FLAG_RIGHT   = 4;
	localparam int FLAG_UP      = 5;
	localparam int FLAG_DOWN    = 6;

	typedef enum logic [1:0] {
		KIND_SWITCH  = 2'd0,
		KIND_PTZ     = 2'd1,
		KIND_UNKNOWN = 2'd2
	} kind_t;

	// Decoded message, compared as a whole against the last posted one
	typedef struct packed {
		kind_t      kind;
		logic [7:0] camera;
		logic [7:0] monitor;
		logic [6:0] flags;
		logic [6:0] pan;
		logic [6:0] tilt;
	} msg_t;

	// Queue entry carried from front to back
	typedef struct packed {
		msg_t msg;
		logic confirm;
	} entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/keyboard_packet_decoder_core.sv]
// Keyboard packet decoder: top level joining front, queue and back.
// Throughput: one rx byte per cycle while rx_stall is low; an 8-byte packet yields at most one message.
// Accepting packet byte 7 writes its entry into the queue; the back end pops it into the output register.
// The queue of QUEUE_DEPTH entries lets framing continue while msg_stall holds.
// Reset (arst_n low, asynchronous) returns to sync hunt, empties the queue,
// drops the output and forgets the last posted message.
module keyboard_packet_decoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       msg_valid,
	input  logic       msg_stall,
	output logic [1:0] msg_kind,
	output logic [7:0] camera,
	output logic [7:0] monitor,
	output logic [6:0] ptz_flags,
	output logic [6:0] pan_step,
	output logic [6:0] tilt_step,
	output logic       new_message,
	output logic       send_confirm
);

	kpd_pkg::q_status_t q_status;
	kpd_pkg::entry_t    push_entry;
	kpd_pkg::entry_t    head;
	kpd_pkg::entry_t    out_entry;
	logic               push;
	logic               pop;

	kpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	kpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	kpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.out_entry (out_entry),
		.out_new   (new_message)
	);

	// Unpack the output entry onto the ports
	assign msg_kind     = out_entry.msg.kind;
	assign camera       = out_entry.msg.camera;
	assign monitor      = out_entry.msg.monitor;
	assign ptz_flags    = out_entry.msg.flags;
	assign pan_step     = out_entry.msg.pan;
	assign tilt_step    = out_entry.msg.tilt;
	assign send_confirm = out_entry.confirm;

endmodule

[rtl/kpd_front.sv]
// Front end: frames packets from the byte stream and decodes completed ones.
module kpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	input  kpd_pkg::q_status_t q_status,
	output logic               push,
	output kpd_pkg::entry_t    push_entry
);

	logic [2:0] pos_q;
	logic [7:0] cmd_q;
	logic [7:0] b3_q;
	logic [7:0] cam_q;
	logic [7:0] b5_q;
	logic [7:0] b6_q;
	logic       accept;
	logic [6:0] pan;
	logic [6:0] tilt;
	logic [6:0] flags;

	// Hold the last byte only while the queue is full
	assign rx_stall = (pos_q == kpd_pkg::POS_LAST) && q_status.full;
	assign accept   = rx_valid && !rx_stall;
	assign push     = accept && (pos_q == kpd_pkg::POS_LAST);

	// Advance the byte position: hunt for sync, then count seven bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= kpd_pkg::POS_HUNT;
		end else if (accept) begin
			if (pos_q == kpd_pkg::POS_HUNT) begin
				if (rx_byte == kpd_pkg::SYNC_BYTE) begin
					pos_q <= 3'd1;
				end
			end else if (pos_q == kpd_pkg::POS_LAST) begin
				pos_q <= kpd_pkg::POS_HUNT;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	// Capture packet bytes 2 to 6
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == kpd_pkg::POS_CMD) cmd_q <= rx_byte;
			if (pos_q == kpd_pkg::POS_B3)  b3_q  <= rx_byte;
			if (pos_q == kpd_pkg::POS_CAM) cam_q <= rx_byte;
			if (pos_q == kpd_pkg::POS_B5)  b5_q  <= rx_byte;
			if (pos_q == kpd_pkg::POS_B6)  b6_q  <= rx_byte;
		end
	end

	// Decode pan/tilt/zoom fields
	assign pan  = b5_q[6:0];
	assign tilt = b6_q[6:0];

	always_comb begin
		flags = '0;
		flags[kpd_pkg::FLAG_STOP]    = (b3_q == 8'd0) && (b5_q == 8'd0) && (b6_q == 8'd0);
		flags[kpd_pkg::FLAG_ZOOMIN]  = (b3_q == kpd_pkg::ZOOM_IN_CODE);
		flags[kpd_pkg::FLAG_ZOOMOUT] = (b3_q == kpd_pkg::ZOOM_OUT_CODE);
		flags[kpd_pkg::FLAG_LEFT]    = (pan != 7'd0) && !b5_q[7];
		flags[kpd_pkg::FLAG_RIGHT]   = (pan != 7'd0) && b5_q[7];
		flags[kpd_pkg::FLAG_UP]      = (tilt != 7'd0) && !b6_q[7];
		flags[kpd_pkg::FLAG_DOWN]    = (tilt != 7'd0) && b6_q[7];
	end

	// Build the queue entry by command
	always_comb begin
		push_entry             = '0;
		push_entry.msg.camera  = cam_q;
		push_entry.confirm     = (cmd_q == kpd_pkg::CMD_REGISTER);
		if (cmd_q == kpd_pkg::CMD_SWITCH) begin
			push_entry.msg.kind    = kpd_pkg::KIND_SWITCH;
			push_entry.msg.monitor = b5_q;
		end else if (cmd_q == kpd_pkg::CMD_PTZ) begin
			push_entry.msg.kind  = kpd_pkg::KIND_PTZ;
			push_entry.msg.flags = flags;
			push_entry.msg.pan   = pan;
			push_entry.msg.tilt  = tilt;
		end else begin
			push_entry.msg.kind = kpd_pkg::KIND_UNKNOWN;
		end
	end

endmodule

[rtl/kpd_queue.sv]
// Short register queue between the decoder front and back.
module kpd_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kpd_pkg::entry_t    push_entry,
	input  logic               pop,
	output kpd_pkg::entry_t    head,
	output kpd_pkg::q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	kpd_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (count_q == DEPTH_CNT);
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/kpd_back.sv]
// Back end: marks repeated messages and drives the output register.
module kpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  kpd_pkg::q_status_t q_status,
	input  kpd_pkg::entry_t    head,
	output logic               pop,
	output logic               msg_valid,
	input  logic               msg_stall,
	output kpd_pkg::entry_t    out_entry,
	output logic               out_new
);

	logic            out_valid_q;
	kpd_pkg::entry_t out_entry_q;
	logic            out_new_q;
	kpd_pkg::msg_t   last_q;
	logic            last_valid_q;
	logic            is_new;

	// Take the next entry when the output register is free or being drained
	assign pop    = !q_status.empty && (!out_valid_q || !msg_stall);
	assign is_new = !last_valid_q || (head.msg != last_q);

	// Track output valid and the last posted message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			last_valid_q <= 1'b0;
			last_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!msg_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && is_new) begin
				last_q       <= head.msg;
				last_valid_q <= 1'b1;
			end
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_entry_q <= head;
			out_new_q   <= is_new;
		end
	end

	assign msg_valid = out_valid_q;
	assign out_entry = out_entry_q;
	assign out_new   = out_new_q;

endmodule

[rtl/kpd_checker.sv]
// Port-level checks of the keyboard packet decoder, bound to the top level.
module kpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_stall,
	input logic [1:0] msg_kind,
	input logic [7:0] camera,
	input logic [7:0] monitor,
	input logic [6:0] ptz_flags,
	input logic [6:0] pan_step,
	input logic [6:0] tilt_step,
	input logic       new_message,
	input logic       send_confirm
);

	// Hold a stalled transaction
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_stall |=> msg_valid && $stable(camera) && $stable(msg_kind)
			&& $stable(ptz_flags) && $stable(new_message))
		else $error("stalled transaction changed");

	// Drop output valid once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !msg_valid)
		else $error("msg_valid during reset");

	// Zero the motion fields outside pan tilt zoom
	a_ptz_only: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind != kpd_pkg::KIND_PTZ |->
			ptz_flags == 7'd0 && pan_step == 7'd0 && tilt_step == 7'd0)
		else $error("motion fields set outside pan tilt zoom");

	// Zero the monitor outside a switch
	a_monitor_switch: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind != kpd_pkg::KIND_SWITCH |-> monitor == 8'd0)
		else $error("monitor set outside switch");

	// Confirm only on unknown commands, with exclusive direction bits on motion
	a_confirm_kind: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> (!send_confirm || msg_kind == kpd_pkg::KIND_UNKNOWN)
			&& !(ptz_flags[kpd_pkg::FLAG_LEFT] && ptz_flags[kpd_pkg::FLAG_RIGHT])
			&& !(ptz_flags[kpd_pkg::FLAG_UP] && ptz_flags[kpd_pkg::FLAG_DOWN]))
		else $error("confirm or direction flags inconsistent");

endmodule

bind keyboard_packet_decoder_core kpd_checker u_kpd_checker (.*);

[sim/tb.sv]
// Testbench for the keyboard packet decoder: random byte streams checked against a scoreboard.
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_BYTES   = 1350;
	localparam int CALM_BYTES     = 150;
	localparam int HOLD_AT_BYTES  = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 4000;

	// Expected message as the block should post it
	typedef struct packed {
		kpd_pkg::msg_t msg;
		logic          fresh;
		logic          confirm;
	} decoded_t;

	// Byte framer, decoder and expected-message store
	class msg_scoreboard;
		logic [2:0]    frame_pos;
		logic [7:0]    frame_bytes [5];
		kpd_pkg::msg_t posted_msg;
		logic          posted_valid;
		decoded_t      pending_msgs [$];
		int            mismatches;
		int            checked;
		int            n_switch;
		int            n_ptz;
		int            n_unknown;
		int            n_confirm;
		int            n_repeat;
		int            n_stop;

		function new();
			frame_pos    = kpd_pkg::POS_HUNT;
			posted_msg   = '0;
			posted_valid = 1'b0;
			mismatches   = 0;
			checked      = 0;
			n_switch     = 0;
			n_ptz        = 0;
			n_unknown    = 0;
			n_confirm    = 0;
			n_repeat     = 0;
			n_stop       = 0;
			foreach (frame_bytes[i])
				frame_bytes[i] = '0;
		endfunction

		task report(input string what);
			$display("[%0t] MISMATCH %s", $realtime, what);
			mismatches++;
		endtask

		// Build the message from the five stored packet bytes
		function decoded_t decode_frame();
			decoded_t   d;
			logic [7:0] cmd;
			logic [7:0] b3;
			logic [7:0] b5;
			logic [7:0] b6;
			cmd = frame_bytes[0];
			b3  = frame_bytes[1];
			b5  = frame_bytes[3];
			b6  = frame_bytes[4];
			d = '0;
			d.msg.camera = frame_bytes[2];
			if (cmd == kpd_pkg::CMD_SWITCH) begin
				d.msg.kind    = kpd_pkg::KIND_SWITCH;
				d.msg.monitor = b5;
			end else if (cmd == kpd_pkg::CMD_PTZ) begin
				d.msg.kind = kpd_pkg::KIND_PTZ;
				d.msg.pan  = b5[6:0];
				d.msg.tilt = b6[6:0];
				if (b3 == 8'h00 && b5 == 8'h00 && b6 == 8'h00)
					d.msg.flags[kpd_pkg::FLAG_STOP] = 1'b1;
				if (b3 == kpd_pkg::ZOOM_IN_CODE)
					d.msg.flags[kpd_pkg::FLAG_ZOOMIN] = 1'b1;
				else if (b3 == kpd_pkg::ZOOM_OUT_CODE)
					d.msg.flags[kpd_pkg::FLAG_ZOOMOUT] = 1'b1;
				if (d.msg.pan != '0)
					d.msg.flags[b5[7] ? kpd_pkg::FLAG_RIGHT : kpd_pkg::FLAG_LEFT] = 1'b1;
				if (d.msg.tilt != '0)
					d.msg.flags[b6[7] ? kpd_pkg::FLAG_DOWN : kpd_pkg::FLAG_UP] = 1'b1;
			end else begin
				d.msg.kind = kpd_pkg::KIND_UNKNOWN;
			end
			d.confirm = (cmd == kpd_pkg::CMD_REGISTER);
			d.fresh   = !posted_valid || (d.msg != posted_msg);
			return d;
		endfunction

		// Advance the framer by one accepted byte; return 0 when the byte is dropped in hunt
		function bit note_rx_byte(input logic [7:0] b);
			decoded_t d;
			if (frame_pos == kpd_pkg::POS_HUNT) begin
				if (b == kpd_pkg::SYNC_BYTE)
					frame_pos = 3'd1;
				return b == kpd_pkg::SYNC_BYTE;
			end
			if (frame_pos != kpd_pkg::POS_LAST) begin
				if (frame_pos >= kpd_pkg::POS_CMD)
					frame_bytes[frame_pos - kpd_pkg::POS_CMD] = b;
				frame_pos = frame_pos + 3'd1;
				return 1'b1;
			end
			frame_pos = kpd_pkg::POS_HUNT;
			d = decode_frame();
			if (d.fresh) begin
				posted_msg   = d.msg;
				posted_valid = 1'b1;
			end else begin
				n_repeat++;
			end
			case (d.msg.kind)
				kpd_pkg::KIND_SWITCH: n_switch++;
				kpd_pkg::KIND_PTZ:    n_ptz++;
				default:              n_unknown++;
			endcase
			if (d.confirm)
				n_confirm++;
			if (d.msg.flags[kpd_pkg::FLAG_STOP])
				n_stop++;
			pending_msgs.push_back(d);
			return 1'b1;
		endfunction

		// Compare one accepted message with the oldest expectation
		task check_msg(input decoded_t got);
			decoded_t want;
			if (pending_msgs.size() == 0) begin
				report($sformatf("unexpected message kind=%0d camera=%0d", got.msg.kind,
					got.msg.camera));
				return;
			end
			want = pending_msgs.pop_front();
			checked++;
			if (got.msg.kind !== want.msg.kind)
				report($sformatf("msg_kind got %0d want %0d", got.msg.kind, want.msg.kind));
			if (got.msg.camera !== want.msg.camera)
				report($sformatf("camera got %0d want %0d", got.msg.camera, want.msg.camera));
			if (got.msg.monitor !== want.msg.monitor)
				report($sformatf("monitor got %0d want %0d", got.msg.monitor,
					want.msg.monitor));
			if (got.msg.flags !== want.msg.flags)
				report($sformatf("ptz_flags got %b want %b", got.msg.flags, want.msg.flags));
			if (got.msg.pan !== want.msg.pan)
				report($sformatf("pan_step got %0d want %0d", got.msg.pan, want.msg.pan));
			if (got.msg.tilt !== want.msg.tilt)
				report($sformatf("tilt_step got %0d want %0d", got.msg.tilt, want.msg.tilt));
			if (got.fresh !== want.fresh)
				report($sformatf("new_message got %b want %b", got.fresh, want.fresh));
			if (got.confirm !== want.confirm)
				report($sformatf("send_confirm got %b want %b", got.confirm, want.confirm));
		endtask
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       msg_valid;
	logic       msg_stall = 1'b0;
	logic [1:0] msg_kind;
	logic [7:0] camera;
	logic [7:0] monitor;
	logic [6:0] ptz_flags;
	logic [6:0] pan_step;
	logic [6:0] tilt_step;
	logic       new_message;
	logic       send_confirm;

	msg_scoreboard sb;
	bit            calm       = 1'b0;
	bit            hold_req   = 1'b0;
	bit            hold_taken = 1'b0;
	bit            tx_gappy   = 1'b1;
	int            framed_bytes = 0;
	logic [7:0]    last_packet [8];

	keyboard_packet_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg_kind     (msg_kind),
		.camera       (camera),
		.monitor      (monitor),
		.ptz_flags    (ptz_flags),
		.pan_step     (pan_step),
		.tilt_step    (tilt_step),
		.new_message  (new_message),
		.send_confirm (send_confirm)
	);

	// Generate the clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one byte, optionally after an idle burst, and hold it until the transaction
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!calm && tx_gappy && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
		if (sb.note_rx_byte(b))
			framed_bytes++;
	endtask

	// Pick a speed byte biased toward zero, sign-only and full-scale values
	function automatic logic [7:0] pick_speed();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'h80;
			2:       return 8'h7F;
			3:       return 8'hFF;
			4:       return 8'(($urandom_range(0, 1) << 7) | $urandom_range(1, 3));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one well-formed packet with random content, sometimes a repeat of the last one
	task automatic send_packet();
		logic [7:0] pkt [8];
		if ($urandom_range(0, 5) == 0) begin
			pkt = last_packet;
		end else begin
			pkt[0] = kpd_pkg::SYNC_BYTE;
			pkt[1] = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0, 1, 2:    pkt[2] = kpd_pkg::CMD_SWITCH;
				3, 4, 5, 6: pkt[2] = kpd_pkg::CMD_PTZ;
				7:          pkt[2] = kpd_pkg::CMD_REGISTER;
				default:    pkt[2] = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 4))
				0, 1:    pkt[3] = 8'h00;
				2:       pkt[3] = kpd_pkg::ZOOM_IN_CODE;
				3:       pkt[3] = kpd_pkg::ZOOM_OUT_CODE;
				default: pkt[3] = 8'($urandom_range(0, 255));
			endcase
			pkt[4] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
			pkt[5] = pick_speed();
			pkt[6] = pick_speed();
			pkt[7] = 8'($urandom_range(0, 255));
		end
		last_packet = pkt;
		foreach (pkt[i])
			send_byte(pkt[i]);
	endtask

	// Send hunt noise or a truncated packet that swallows the next sync
	task automatic send_noise();
		int n;
		if ($urandom_range(0, 2) == 0) begin
			send_byte(kpd_pkg::SYNC_BYTE);
			n = $urandom_range(1, 6);
		end else begin
			n = $urandom_range(1, 4);
		end
		repeat (n)
			send_byte($urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 254)));
	endtask

	// Receive side: check messages and stall in bursts, with one long hold-off
	initial begin
		decoded_t got;
		int       stall_left;
		bit       rx_gappy;
		stall_left = 0;
		rx_gappy   = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && msg_valid && !msg_stall) begin
				got.msg.kind    = kpd_pkg::kind_t'(msg_kind);
				got.msg.camera  = camera;
				got.msg.monitor = monitor;
				got.msg.flags   = ptz_flags;
				got.msg.pan     = pan_step;
				got.msg.tilt    = tilt_step;
				got.fresh       = new_message;
				got.confirm     = send_confirm;
				sb.check_msg(got);
			end
			if ($urandom_range(0, 99) == 0)
				rx_gappy = !rx_gappy;
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				msg_stall <= 1'b1;
			end else if (!calm && rx_gappy && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				msg_stall <= 1'b1;
			end else begin
				msg_stall <= 1'b0;
			end
		end
	end

	// End the run when no transaction happens for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((rx_valid && !rx_stall) || (msg_valid && !msg_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed packets, random traffic, drain
	initial begin
		logic [7:0] directed [$];
		sb = new();
		foreach (last_packet[i])
			last_packet[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hunt noise, stop with a sync byte taken as data, its repeat,
		// zoom in with right and down, and a register confirm request
		directed = '{8'h00,
			8'hFF, 8'hFF, kpd_pkg::CMD_PTZ, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
			8'hFF, 8'hFF, kpd_pkg::CMD_PTZ, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
			8'hFF, 8'h7F, kpd_pkg::CMD_PTZ, kpd_pkg::ZOOM_IN_CODE, 8'h80, 8'h81, 8'hFF,
			8'h55,
			8'hFF, 8'h00, kpd_pkg::CMD_REGISTER, kpd_pkg::ZOOM_OUT_CODE, 8'h00, 8'h7F,
			8'h01, 8'hAA};
		foreach (directed[i])
			send_byte(directed[i]);

		// Random traffic, mostly well-formed packets
		while (framed_bytes < RANDOM_BYTES) begin
			if (framed_bytes >= HOLD_AT_BYTES)
				hold_req = 1'b1;
			if (framed_bytes >= RANDOM_BYTES - CALM_BYTES)
				calm = 1'b1;
			if ($urandom_range(0, 9) == 0)
				tx_gappy = !tx_gappy;
			if ($urandom_range(0, 7) == 0)
				send_noise();
			else
				send_packet();
		end
		rx_valid <= 1'b0;

		// Drain expected messages, then let the pipeline settle
		while (sb.pending_msgs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_msgs.size() != 0)
			sb.report($sformatf("%0d expected messages never arrived",
				sb.pending_msgs.size()));

		$display("Covered %0d framed bytes, %0d messages checked:", framed_bytes, sb.checked);
		$display("%0d switch, %0d ptz, %0d unknown, %0d register confirms, %0d stops, %0d repeats",
			sb.n_switch, sb.n_ptz, sb.n_unknown, sb.n_confirm, sb.n_stop, sb.n_repeat);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/kpd_pkg.sv
rtl/kpd_front.sv
rtl/kpd_queue.sv
rtl/kpd_back.sv
rtl/keyboard_packet_decoder_core.sv
rtl/kpd_checker.sv
sim/tb.sv
